### rtl/core/can_frame_rx_ring_status_table_unit_defines.svh
// Assertion helpers shared by the receive ring design.
`ifndef CAN_FRAME_RX_RING_STATUS_TABLE_UNIT_DEFINES_SVH
`define CAN_FRAME_RX_RING_STATUS_TABLE_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CFRX_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define CFRX_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

### rtl/core/cfrx_pkg.sv
package cfrx_pkg;

	localparam int ID_W      = 11;
	localparam int LEN_W     = 4;
	localparam int PAYLOAD_W = 64;
	localparam int MIDX_W    = 8;
	localparam int BYTE_W    = 8;
	localparam int SPEED_W   = 16;

	localparam int RING_DEPTH_DEF  = 16;
	localparam int MOTOR_SLOTS_DEF = 8;

	// Length thresholds of the status decode.
	localparam logic [LEN_W-1:0] STATUS_MIN_LEN = 4'd5;
	localparam logic [LEN_W-1:0] ERROR_MIN_LEN  = 4'd6;

	typedef enum logic [1:0] {
		OP_RX     = 2'd0,
		OP_POP    = 2'd1,
		OP_STATUS = 2'd2
	} op_t;

	typedef struct packed {
		logic [ID_W-1:0]      id;
		logic [LEN_W-1:0]     length;
		logic [PAYLOAD_W-1:0] payload;
	} frame_t;

	typedef struct packed {
		logic [SPEED_W-1:0] speed;
		logic [BYTE_W-1:0]  direction;
		logic [BYTE_W-1:0]  running;
		logic [BYTE_W-1:0]  error;
	} motor_entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} ring_status_t;

	function automatic logic [BYTE_W-1:0] payload_byte(input logic [PAYLOAD_W-1:0] p,
		input logic [2:0] k);
		return p[k*BYTE_W +: BYTE_W];
	endfunction

endpackage

### rtl/core/cfrx_if.sv
interface cfrx_req_if import cfrx_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [1:0]           op;
	logic [ID_W-1:0]      rx_id;
	logic [LEN_W-1:0]     rx_length;
	logic [PAYLOAD_W-1:0] rx_payload;
	logic [MIDX_W-1:0]    motor_index;

	modport source (output valid, op, rx_id, rx_length, rx_payload, motor_index, input ready);
	modport sink (input valid, op, rx_id, rx_length, rx_payload, motor_index, output ready);
endinterface

interface cfrx_rsp_if import cfrx_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic                 frame_present;
	logic [ID_W-1:0]      out_id;
	logic [LEN_W-1:0]     out_length;
	logic [PAYLOAD_W-1:0] out_payload;
	logic                 dropped;
	logic [SPEED_W-1:0]   motor_speed;
	logic [BYTE_W-1:0]    motor_direction;
	logic [BYTE_W-1:0]    motor_running;
	logic [BYTE_W-1:0]    motor_error;

	modport source (output valid, frame_present, out_id, out_length, out_payload, dropped,
		motor_speed, motor_direction, motor_running, motor_error, input ready);
	modport sink (input valid, frame_present, out_id, out_length, out_payload, dropped,
		motor_speed, motor_direction, motor_running, motor_error, output ready);
endinterface

interface cfrx_cfg_if import cfrx_pkg::*; ();
	logic            valid;
	logic            ready;
	logic [ID_W-1:0] status_frame_id;

	modport source (output valid, status_frame_id, input ready);
	modport sink (input valid, status_frame_id, output ready);
endinterface

### rtl/core/can_frame_rx_ring_status_table_unit.sv
// Stage 1 takes a request at accept; stage 2 takes it once free and offers the
// result. One request per cycle while results are taken; ring and status table
// each take at most one access per request; reads register before stage 2.
// Reset clears the ring pointers, the status table valid bits and the status
// identifier register at once; ring contents are not cleared and no sweep runs.
`include "can_frame_rx_ring_status_table_unit_defines.svh"

module can_frame_rx_ring_status_table_unit import cfrx_pkg::*; #(
	parameter int RING_DEPTH  = RING_DEPTH_DEF,
	parameter int MOTOR_SLOTS = MOTOR_SLOTS_DEF
) (
	input logic        clk,
	input logic        arst_n,
	cfrx_req_if.sink   req,
	cfrx_rsp_if.source rsp,
	cfrx_cfg_if.sink   cfg
);

	logic [ID_W-1:0] status_id_q;

	logic         acc;
	logic         adv_s2;
	logic         move_s1;
	op_t          req_op;
	ring_status_t ring_st;
	frame_t       wr_frame;
	frame_t       rd_frame;
	motor_entry_t rd_entry;

	logic valid_s1;
	op_t  op_s1;
	logic dropped_s1;
	logic present_s1;

	logic                 valid_s2;
	logic                 present_s2;
	frame_t               frame_s2;
	logic                 dropped_s2;
	motor_entry_t         entry_s2;

	assign req_op  = op_t'(req.op);
	assign adv_s2  = !valid_s2 || rsp.ready;
	assign move_s1 = valid_s1 && adv_s2;

	assign req.ready = !valid_s1 || adv_s2;
	assign acc       = req.valid && req.ready;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_id_q <= '0;
		end else if (cfg.valid) begin
			status_id_q <= cfg.status_frame_id;
		end
	end

	assign wr_frame.id      = req.rx_id;
	assign wr_frame.length  = req.rx_length;
	assign wr_frame.payload = req.rx_payload;

	cfrx_ring #(
		.RING_DEPTH(RING_DEPTH)
	) u_ring (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (acc && req_op == OP_RX),
		.pop     (acc && req_op == OP_POP),
		.wr_frame(wr_frame),
		.status  (ring_st),
		.rd_frame(rd_frame)
	);

	cfrx_status #(
		.MOTOR_SLOTS(MOTOR_SLOTS)
	) u_status (
		.clk            (clk),
		.arst_n         (arst_n),
		.rx_en          (acc && req_op == OP_RX),
		.rx_id          (req.rx_id),
		.rx_length      (req.rx_length),
		.rx_payload     (req.rx_payload),
		.status_frame_id(status_id_q),
		.rd_en          (acc && req_op == OP_STATUS),
		.rd_index       (req.motor_index),
		.rd_entry       (rd_entry)
	);

	// All state changes happen at accept; stage 1 only carries what the
	// result needs alongside the registered ring and table reads.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (acc) begin
				valid_s1 <= 1'b1;
			end else if (adv_s2) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// The drop and present flags are only ever set for their own ops, so they
	// pass straight through; the table read is kept only for a status request.
	always_ff @(posedge clk) begin
		if (acc) begin
			op_s1      <= req_op;
			dropped_s1 <= (req_op == OP_RX) && ring_st.full;
			present_s1 <= (req_op == OP_POP) && !ring_st.empty;
		end
		if (move_s1) begin
			present_s2 <= present_s1;
			frame_s2   <= present_s1 ? rd_frame : '0;
			dropped_s2 <= dropped_s1;
			entry_s2   <= (op_s1 == OP_STATUS) ? rd_entry : '0;
		end
	end

	assign rsp.valid           = valid_s2;
	assign rsp.frame_present   = present_s2;
	assign rsp.out_id          = frame_s2.id;
	assign rsp.out_length      = frame_s2.length;
	assign rsp.out_payload     = frame_s2.payload;
	assign rsp.dropped         = dropped_s2;
	assign rsp.motor_speed     = entry_s2.speed;
	assign rsp.motor_direction = entry_s2.direction;
	assign rsp.motor_running   = entry_s2.running;
	assign rsp.motor_error     = entry_s2.error;

	`CFRX_ASSERT_NEXT(a_full_drops, clk, arst_n, acc && req_op == OP_RX && ring_st.full, dropped_s1)
	`CFRX_ASSERT_NEXT(a_pop_finds, clk, arst_n, acc && req_op == OP_POP && !ring_st.empty, present_s1)
	`CFRX_ASSERT_NOW(a_stall_cause, clk, arst_n, !req.ready, valid_s1 && valid_s2 && !rsp.ready)

endmodule

### rtl/core/cfrx_ring.sv
module cfrx_ring import cfrx_pkg::*; #(
	parameter int RING_DEPTH = RING_DEPTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic         pop,
	input  frame_t       wr_frame,
	output ring_status_t status,
	output frame_t       rd_frame
);

	localparam int PTR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam logic [PTR_W-1:0] LAST = PTR_W'(RING_DEPTH - 1);

	frame_t           mem_q [RING_DEPTH];
	frame_t           rd_frame_q;
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W-1:0] wr_next;
	logic [PTR_W-1:0] rd_next;
	logic             do_write;
	logic             do_read;

	assign wr_next = (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
	assign rd_next = (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;

	// One slot always stays free, so equal pointers mean empty.
	assign status.empty = (wr_ptr_q == rd_ptr_q);
	assign status.full  = (wr_next == rd_ptr_q);

	assign do_write = push && !status.full;
	assign do_read  = pop && !status.empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
		end else begin
			if (do_write) begin
				wr_ptr_q <= wr_next;
			end
			if (do_read) begin
				rd_ptr_q <= rd_next;
			end
		end
	end

	// Write and read never hit the same slot: a read needs a non-empty ring.
	always_ff @(posedge clk) begin
		if (do_write) begin
			mem_q[wr_ptr_q] <= wr_frame;
		end
		if (do_read) begin
			rd_frame_q <= mem_q[rd_ptr_q];
		end
	end

	assign rd_frame = rd_frame_q;

endmodule

### rtl/core/cfrx_status.sv
module cfrx_status import cfrx_pkg::*; #(
	parameter int MOTOR_SLOTS = MOTOR_SLOTS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 rx_en,
	input  logic [ID_W-1:0]      rx_id,
	input  logic [LEN_W-1:0]     rx_length,
	input  logic [PAYLOAD_W-1:0] rx_payload,
	input  logic [ID_W-1:0]      status_frame_id,
	input  logic                 rd_en,
	input  logic [MIDX_W-1:0]    rd_index,
	output motor_entry_t         rd_entry
);

	localparam int IDX_W = (MOTOR_SLOTS > 1) ? $clog2(MOTOR_SLOTS) : 1;
	localparam logic [MIDX_W-1:0] SLOTS = MIDX_W'(MOTOR_SLOTS);

	typedef struct packed {
		logic [SPEED_W-1:0] speed;
		logic [BYTE_W-1:0]  direction;
		logic [BYTE_W-1:0]  running;
	} main_t;

	main_t               main_mem_q [MOTOR_SLOTS];
	logic [BYTE_W-1:0]   err_mem_q  [MOTOR_SLOTS];
	logic [MOTOR_SLOTS-1:0] main_vld_q;

	main_t             rd_main_q;
	logic [BYTE_W-1:0] rd_err_q;
	logic              rd_main_ok_q;

	logic [MIDX_W-1:0] slot;
	logic [IDX_W-1:0]  wr_idx;
	logic [IDX_W-1:0]  rd_idx;
	logic              upd;
	logic              upd_err;
	logic              rd_in_range;
	main_t             wr_main;

	assign slot   = payload_byte(rx_payload, 3'd0);
	assign wr_idx = slot[IDX_W-1:0];
	assign rd_idx = rd_index[IDX_W-1:0];

	assign upd = rx_en && (rx_id == status_frame_id) && (rx_length >= STATUS_MIN_LEN)
		&& (slot < SLOTS);
	assign upd_err     = upd && (rx_length >= ERROR_MIN_LEN);
	assign rd_in_range = rd_index < SLOTS;

	assign wr_main.speed     = {payload_byte(rx_payload, 3'd1), payload_byte(rx_payload, 3'd2)};
	assign wr_main.direction = payload_byte(rx_payload, 3'd3);
	assign wr_main.running   = payload_byte(rx_payload, 3'd4);

	// Valid bits stand in for the table clear: an entry never written reads as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_vld_q   <= '0;
			rd_main_ok_q <= 1'b0;
		end else begin
			if (upd) begin
				main_vld_q[wr_idx] <= 1'b1;
			end
			if (rd_en) begin
				rd_main_ok_q <= rd_in_range && main_vld_q[rd_idx];
			end
		end
	end

	// The first update of an entry without an error byte stores a zero error, so
	// one valid bit covers the whole entry.
	always_ff @(posedge clk) begin
		if (upd) begin
			main_mem_q[wr_idx] <= wr_main;
		end
		if (upd_err) begin
			err_mem_q[wr_idx] <= payload_byte(rx_payload, 3'd5);
		end else if (upd && !main_vld_q[wr_idx]) begin
			err_mem_q[wr_idx] <= '0;
		end
		if (rd_en) begin
			rd_main_q <= main_mem_q[rd_idx];
			rd_err_q  <= err_mem_q[rd_idx];
		end
	end

	assign rd_entry.speed     = rd_main_ok_q ? rd_main_q.speed : '0;
	assign rd_entry.direction = rd_main_ok_q ? rd_main_q.direction : '0;
	assign rd_entry.running   = rd_main_ok_q ? rd_main_q.running : '0;
	assign rd_entry.error     = rd_main_ok_q ? rd_err_q : '0;

endmodule

### test/testbench.sv
`timescale 1ns / 100ps

module testbench import cfrx_pkg::*; ();

	// Op code 3 has no meaning: the block leaves its state alone and answers with zeros.
	localparam logic [1:0] OP_RESERVED = 2'd3;

	localparam int SETTLE_CYCLES = 4;
	localparam int HOLD_CYCLES   = 120;
	localparam int STALL_LIMIT   = 1000;

	typedef struct packed {
		logic [1:0]           op;
		logic [ID_W-1:0]      rx_id;
		logic [LEN_W-1:0]     rx_length;
		logic [PAYLOAD_W-1:0] rx_payload;
		logic [MIDX_W-1:0]    motor_index;
	} request_t;

	typedef struct packed {
		logic                 frame_present;
		logic [ID_W-1:0]      out_id;
		logic [LEN_W-1:0]     out_length;
		logic [PAYLOAD_W-1:0] out_payload;
		logic                 dropped;
		motor_entry_t         motor;
	} result_t;

	logic clk;
	logic arst_n;

	cfrx_req_if req_bus();
	cfrx_rsp_if rsp_bus();
	cfrx_cfg_if cfg_bus();

	can_frame_rx_ring_status_table_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_bus),
		.rsp    (rsp_bus),
		.cfg    (cfg_bus)
	);

	// Local copy of the receive ring, the motor table and the status identifier.
	frame_t          ring_model [RING_DEPTH_DEF];
	int              ring_wr;
	int              ring_rd;
	motor_entry_t    motor_table [MOTOR_SLOTS_DEF];
	logic [ID_W-1:0] status_id_model;

	result_t expected_results [$];
	int      mismatch_count;
	int      quiet_cycles;
	bit      no_idle;
	bit      hold_request;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic result_t compute_rx_result(input request_t r);
		result_t res;
		int      next_wr;
		int      slot;
		res = '0;
		case (r.op)
			OP_RX: begin
				next_wr = (ring_wr + 1) % RING_DEPTH_DEF;
				if (next_wr != ring_rd) begin
					ring_model[ring_wr] = {r.rx_id, r.rx_length, r.rx_payload};
					ring_wr = next_wr;
				end else begin
					res.dropped = 1'b1;
				end
				// The status decode runs even when the frame itself is dropped.
				if (r.rx_id == status_id_model && r.rx_length >= STATUS_MIN_LEN) begin
					slot = r.rx_payload[7:0];
					if (slot < MOTOR_SLOTS_DEF) begin
						motor_table[slot].speed     = {r.rx_payload[15:8], r.rx_payload[23:16]};
						motor_table[slot].direction = r.rx_payload[31:24];
						motor_table[slot].running   = r.rx_payload[39:32];
						if (r.rx_length >= ERROR_MIN_LEN)
							motor_table[slot].error = r.rx_payload[47:40];
					end
				end
			end
			OP_POP: begin
				if (ring_wr != ring_rd) begin
					res.frame_present = 1'b1;
					res.out_id        = ring_model[ring_rd].id;
					res.out_length    = ring_model[ring_rd].length;
					res.out_payload   = ring_model[ring_rd].payload;
					ring_rd = (ring_rd + 1) % RING_DEPTH_DEF;
				end
			end
			OP_STATUS: begin
				if (r.motor_index < MOTOR_SLOTS_DEF)
					res.motor = motor_table[r.motor_index];
			end
			default: ;
		endcase
		return res;
	endfunction

	function automatic request_t build_request(input logic [1:0] op, input logic [ID_W-1:0] id,
		input logic [LEN_W-1:0] len, input logic [PAYLOAD_W-1:0] payload,
		input logic [MIDX_W-1:0] midx);
		request_t r;
		r.op          = op;
		r.rx_id       = id;
		r.rx_length   = len;
		r.rx_payload  = payload;
		r.motor_index = midx;
		return r;
	endfunction

	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (no_idle || roll < 55)
			return 0;
		if (roll < 85)
			return $urandom_range(1, 3);
		if (roll < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 50);
	endfunction

	function automatic request_t random_request(input int pop_pct);
		request_t r;
		int       roll;
		roll = $urandom_range(0, 99);
		r = build_request(OP_RX, ID_W'($urandom_range(0, 2047)), LEN_W'($urandom_range(0, 8)),
			{$urandom, $urandom}, MIDX_W'($urandom_range(0, 255)));
		if ($urandom_range(0, 7) == 0)
			r.rx_length = LEN_W'($urandom_range(9, 15));
		if ($urandom_range(0, 15) == 0)
			r.rx_payload = $urandom_range(0, 1) ? '1 : '0;
		if (roll < pop_pct) begin
			r.op = OP_POP;
		end else if (roll < pop_pct + 15) begin
			r.op = OP_STATUS;
			if ($urandom_range(0, 3) != 0)
				r.motor_index = MIDX_W'($urandom_range(0, MOTOR_SLOTS_DEF - 1));
		end else if (roll < pop_pct + 19) begin
			r.op = OP_RESERVED;
		end else if ($urandom_range(0, 1) == 0) begin
			// Well-formed status frame, mostly aimed at an existing motor slot.
			r.rx_id     = status_id_model;
			r.rx_length = LEN_W'($urandom_range(5, 8));
			if ($urandom_range(0, 9) == 0)
				r.rx_length = LEN_W'($urandom_range(0, 15));
			if ($urandom_range(0, 7) != 0)
				r.rx_payload[7:0] = BYTE_W'($urandom_range(0, MOTOR_SLOTS_DEF - 1));
		end
		return r;
	endfunction

	// Valid stays high across back-to-back requests so it never gets two updates in one step.
	task automatic send_request(input request_t r);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			req_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_bus.valid       <= 1'b1;
		req_bus.op          <= r.op;
		req_bus.rx_id       <= r.rx_id;
		req_bus.rx_length   <= r.rx_length;
		req_bus.rx_payload  <= r.rx_payload;
		req_bus.motor_index <= r.motor_index;
		@(posedge clk);
		while (!req_bus.ready)
			@(posedge clk);
		expected_results.push_back(compute_rx_result(r));
	endtask

	task automatic wait_for_idle();
		req_bus.valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_status_id(input logic [ID_W-1:0] value);
		cfg_bus.valid           <= 1'b1;
		cfg_bus.status_frame_id <= value;
		@(posedge clk);
		while (!cfg_bus.ready)
			@(posedge clk);
		status_id_model = value;
		cfg_bus.valid <= 1'b0;
	endtask

	task automatic test_empty_ring_and_reserved_op();
		send_request(build_request(OP_POP, '1, '1, '1, '1));
		send_request(build_request(OP_RESERVED, '1, '1, '1, '1));
	endtask

	task automatic test_ring_fill_and_overflow();
		request_t r;
		for (int i = 0; i < RING_DEPTH_DEF - 1; i++) begin
			r = build_request(OP_RX, ID_W'($urandom_range(0, 2047)), LEN_W'(i % 9),
				{$urandom, $urandom}, '0);
			if (i == 0)
				r.rx_id = '0;
			if (i == 1)
				r.rx_id = '1;
			if (i == 2)
				r.rx_payload = '1;
			if (i == 3)
				r.rx_payload = '0;
			if (i == RING_DEPTH_DEF - 2)
				r.rx_length = '1;
			send_request(r);
		end
		// The ring is full now, so this status frame is dropped but still decoded into slot 3.
		send_request(build_request(OP_RX, '0, 4'd6, 64'h0000_5A01_8012_3403, '0));
		send_request(build_request(OP_POP, '0, '0, '0, '0));
	endtask

	task automatic test_status_decode();
		wait_for_idle();
		write_status_id('1);
		// Length 5 leaves the error byte of slot 3 as it was.
		send_request(build_request(OP_RX, '1, 4'd5, 64'hFFFF_EE77_0155_AA03, '0));
		send_request(build_request(OP_STATUS, '0, '0, '0, 8'd3));
		// Length 15 counts as a full status frame.
		send_request(build_request(OP_RX, '1, 4'd15, 64'hFFFF_FFFF_FFFF_FF07, '0));
		send_request(build_request(OP_STATUS, '0, '0, '0, 8'd7));
		send_request(build_request(OP_STATUS, '0, '0, '0, 8'd255));
	endtask

	task automatic test_random_traffic(input logic [ID_W-1:0] status_id, input int count);
		int pop_pct;
		pop_pct = 30;
		wait_for_idle();
		write_status_id(status_id);
		for (int i = 0; i < count; i++) begin
			if (i % 100 == 0) begin
				no_idle = ($urandom_range(0, 4) == 0);
				case ($urandom_range(0, 3))
					0: pop_pct = 10;
					1: pop_pct = 30;
					2: pop_pct = 45;
					default: pop_pct = 65;
				endcase
			end
			send_request(random_request(pop_pct));
		end
		no_idle = 1'b0;
	endtask

	task automatic test_backpressure();
		wait_for_idle();
		no_idle      = 1'b1;
		hold_request = 1'b1;
		for (int i = 0; i < 60; i++)
			send_request(random_request(30));
		no_idle = 1'b0;
		wait_for_idle();
	endtask

	initial begin : response_sink
		int stall_left;
		int hold_left;
		stall_left = 0;
		hold_left  = 0;
		rsp_bus.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_left    = HOLD_CYCLES;
				hold_request = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_bus.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				rsp_bus.ready <= 1'b0;
			end else begin
				rsp_bus.ready <= 1'b1;
				if (!no_idle && $urandom_range(0, 3) == 0)
					stall_left = pick_gap();
			end
		end
	end

	task automatic check_field(input string name, input logic [63:0] want,
		input logic [63:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatch_count++;
		end
	endtask

	always @(posedge clk) begin
		result_t want;
		if (arst_n && rsp_bus.valid && rsp_bus.ready) begin
			if (expected_results.size() == 0) begin
				$error("result arrived with no request outstanding");
				mismatch_count++;
			end else begin
				want = expected_results.pop_front();
				check_field("frame_present", want.frame_present, rsp_bus.frame_present);
				check_field("out_id", want.out_id, rsp_bus.out_id);
				check_field("out_length", want.out_length, rsp_bus.out_length);
				check_field("out_payload", want.out_payload, rsp_bus.out_payload);
				check_field("dropped", want.dropped, rsp_bus.dropped);
				check_field("motor_speed", want.motor.speed, rsp_bus.motor_speed);
				check_field("motor_direction", want.motor.direction, rsp_bus.motor_direction);
				check_field("motor_running", want.motor.running, rsp_bus.motor_running);
				check_field("motor_error", want.motor.error, rsp_bus.motor_error);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
				(cfg_bus.valid && cfg_bus.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	initial begin
		arst_n          = 1'b0;
		mismatch_count  = 0;
		quiet_cycles    = 0;
		no_idle         = 1'b0;
		hold_request    = 1'b0;
		ring_wr         = 0;
		ring_rd         = 0;
		status_id_model = '0;
		foreach (motor_table[i])
			motor_table[i] = '0;
		foreach (ring_model[i])
			ring_model[i] = '0;
		req_bus.valid           <= 1'b0;
		req_bus.op              <= OP_RX;
		req_bus.rx_id           <= '0;
		req_bus.rx_length       <= '0;
		req_bus.rx_payload      <= '0;
		req_bus.motor_index     <= '0;
		cfg_bus.valid           <= 1'b0;
		cfg_bus.status_frame_id <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_ring_and_reserved_op();
		test_ring_fill_and_overflow();
		test_status_decode();
		test_random_traffic('1, 310);
		test_random_traffic('0, 300);
		test_backpressure();
		test_random_traffic(11'd1, 260);
		test_random_traffic(ID_W'($urandom_range(0, 2047)), 300);
		test_random_traffic(11'd1024, 300);
		wait_for_idle();

		if (mismatch_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/cfrx_pkg.sv
rtl/core/cfrx_if.sv
rtl/core/cfrx_ring.sv
rtl/core/cfrx_status.sv
rtl/core/can_frame_rx_ring_status_table_unit.sv
test/testbench.sv
